>>> sv/kfat_pkg.sv
package kfat_pkg;

	localparam int KEY_W  = 24;
	localparam int KIND_W = 8;
	localparam int IN_F_W = 32;
	localparam int DIV_W  = 32;
	localparam int ST_W   = 3;
	localparam int FUNC_W = 2;

	// operation codes
	localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_DIV   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd3;

	// result status codes
	localparam logic [ST_W-1:0] ST_APPENDED = 3'd0;
	localparam logic [ST_W-1:0] ST_ACCUM    = 3'd1;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd2;
	localparam logic [ST_W-1:0] ST_DIVZERO  = 3'd3;
	localparam logic [ST_W-1:0] ST_ENTRY    = 3'd4;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd5;

	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic [KEY_W-1:0]         partner;
		logic [KIND_W-1:0]        kind_bits;
		logic signed [IN_F_W-1:0] force_x;
		logic signed [IN_F_W-1:0] force_y;
		logic signed [IN_F_W-1:0] force_z;
		logic [DIV_W-1:0]         divisor;
	} cmd_item_t;

	typedef struct packed {
		logic [ST_W-1:0]          status;
		logic                     saturated;
		logic [KEY_W-1:0]         out_partner;
		logic [KIND_W-1:0]        out_kind_bits;
		logic signed [IN_F_W-1:0] out_force_x;
		logic signed [IN_F_W-1:0] out_force_y;
		logic signed [IN_F_W-1:0] out_force_z;
		logic                     last;
	} res_item_t;

	typedef struct packed {
		logic start;
		logic ack;
	} div_ctl_t;

endpackage

>>> sv/kfat_stream_if.sv
interface kfat_stream_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> sv/kfat_cell.sv
module kfat_cell #(
	parameter int FORCE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          shift,
	input  logic [kfat_pkg::KEY_W-1:0]    d_key,
	input  logic [kfat_pkg::KIND_W-1:0]   d_kind,
	input  logic signed [FORCE_WIDTH-1:0] d_fx,
	input  logic signed [FORCE_WIDTH-1:0] d_fy,
	input  logic signed [FORCE_WIDTH-1:0] d_fz,
	output logic [kfat_pkg::KEY_W-1:0]    q_key,
	output logic [kfat_pkg::KIND_W-1:0]   q_kind,
	output logic signed [FORCE_WIDTH-1:0] q_fx,
	output logic signed [FORCE_WIDTH-1:0] q_fy,
	output logic signed [FORCE_WIDTH-1:0] q_fz
);
	import kfat_pkg::*;

	logic [KEY_W-1:0]              key_q;
	logic [KIND_W-1:0]             kind_q;
	logic signed [FORCE_WIDTH-1:0] fx_q, fy_q, fz_q;

	// one table entry; moves one place along the ring on shift
	always_ff @(posedge clk) begin
		if (shift) begin
			key_q  <= d_key;
			kind_q <= d_kind;
			fx_q   <= d_fx;
			fy_q   <= d_fy;
			fz_q   <= d_fz;
		end
	end

	assign q_key  = key_q;
	assign q_kind = kind_q;
	assign q_fx   = fx_q;
	assign q_fy   = fy_q;
	assign q_fz   = fz_q;
endmodule

>>> sv/kfat_div.sv
module kfat_div #(
	parameter int FORCE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kfat_pkg::div_ctl_t            ctl,
	input  logic signed [FORCE_WIDTH-1:0] fx,
	input  logic signed [FORCE_WIDTH-1:0] fy,
	input  logic signed [FORCE_WIDTH-1:0] fz,
	input  logic [kfat_pkg::DIV_W-1:0]    divisor,
	output logic signed [FORCE_WIDTH-1:0] qx,
	output logic signed [FORCE_WIDTH-1:0] qy,
	output logic signed [FORCE_WIDTH-1:0] qz,
	output logic                          sat,
	output logic                          done
);
	import kfat_pkg::*;

	localparam int QW = FORCE_WIDTH + 16;
	localparam int CW = $clog2(QW + 1);
	localparam logic [FORCE_WIDTH-1:0] FMAX = {1'b0, {(FORCE_WIDTH-1){1'b1}}};
	localparam logic [FORCE_WIDTH-1:0] FMIN = {1'b1, {(FORCE_WIDTH-1){1'b0}}};
	localparam logic [QW-1:0] LIM  = QW'(FMAX);
	localparam logic [QW-1:0] LIM1 = QW'(FMAX) + QW'(1);

	typedef enum logic [2:0] {D_IDLE, D_LOAD, D_RUN, D_FIN, D_DONE} dstate_t;

	dstate_t                 state_q;
	logic [1:0]              comp_q;
	logic [CW-1:0]           cnt_q;
	logic [QW-1:0]           quo_q;
	logic [DIV_W-1:0]        rem_q;
	logic [DIV_W-1:0]        dv_q;
	logic                    neg_q;
	logic                    sat_q;
	logic [FORCE_WIDTH-1:0]  f_q [3];
	logic [FORCE_WIDTH-1:0]  r_q [3];

	logic [FORCE_WIDTH-1:0]  cur_f;
	logic [FORCE_WIDTH-1:0]  mag;
	logic [DIV_W:0]          trial;
	logic                    take;
	logic [FORCE_WIDTH-1:0]  fin_val;
	logic                    fin_sat;

	always_comb begin
		cur_f = f_q[comp_q];
		mag   = cur_f[FORCE_WIDTH-1] ? (~cur_f + FORCE_WIDTH'(1)) : cur_f;
		trial = {rem_q, quo_q[QW-1]};
		take  = trial >= {1'b0, dv_q};
		// clamp the magnitude quotient back into the signed range
		fin_sat = |(quo_q >> 63);
		if (!neg_q) begin
			if (quo_q > LIM) begin
				fin_val = FMAX;
				fin_sat = 1'b1;
			end else begin
				fin_val = quo_q[FORCE_WIDTH-1:0];
			end
		end else if (quo_q > LIM1) begin
			fin_val = FMIN;
			fin_sat = 1'b1;
		end else if (quo_q == LIM1) begin
			fin_val = FMIN;
		end else begin
			fin_val = ~quo_q[FORCE_WIDTH-1:0] + FORCE_WIDTH'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			comp_q  <= '0;
			cnt_q   <= '0;
			sat_q   <= 1'b0;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (ctl.start) begin
						f_q[0]  <= fx;
						f_q[1]  <= fy;
						f_q[2]  <= fz;
						dv_q    <= divisor;
						comp_q  <= 2'd0;
						sat_q   <= 1'b0;
						state_q <= D_LOAD;
					end
				end
				D_LOAD: begin
					neg_q   <= cur_f[FORCE_WIDTH-1];
					quo_q   <= {mag, 16'b0};
					rem_q   <= '0;
					cnt_q   <= CW'(QW);
					state_q <= D_RUN;
				end
				D_RUN: begin
					// restoring division, one quotient bit a cycle
					rem_q <= take ? DIV_W'(trial - {1'b0, dv_q}) : trial[DIV_W-1:0];
					quo_q <= {quo_q[QW-2:0], take};
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1))
						state_q <= D_FIN;
				end
				D_FIN: begin
					r_q[comp_q] <= fin_val;
					sat_q       <= sat_q | fin_sat;
					if (comp_q == 2'd2) begin
						state_q <= D_DONE;
					end else begin
						comp_q  <= comp_q + 2'd1;
						state_q <= D_LOAD;
					end
				end
				D_DONE: begin
					if (ctl.ack)
						state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	assign qx   = r_q[0];
	assign qy   = r_q[1];
	assign qz   = r_q[2];
	assign sat  = sat_q;
	assign done = state_q == D_DONE;
endmodule

>>> sv/keyed_force_accumulator_table_top.sv
// Channel | Dir | Payload    | Transaction
// cmd     | in  | cmd_item_t | one operation (clear, add, divide all, read out)
// res     | out | res_item_t | one result; last marks the final one of an operation
//
// Add always rotates the whole ring once. Read out and divide all rotate it once too, unless
//   the table is empty (or, for divide all, the divisor is zero); divide all passes each used
//   entry through the bit-serial divider that serves the head cell. Clear does not rotate.
// Reset: arst_n clears the entry count and the control state; the cells are not reset.
// Stalls: the ring holds while a result waits in the output register and another is due.
module keyed_force_accumulator_table_top #(
	parameter int ENTRIES     = 32,
	parameter int FORCE_WIDTH = 32
) (
	input logic         clk,
	input logic         arst_n,
	kfat_stream_if.sink   cmd,
	kfat_stream_if.source res
);
	import kfat_pkg::*;

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int SW = ((FORCE_WIDTH > 32) ? FORCE_WIDTH : 32) + 1;
	localparam logic [FORCE_WIDTH-1:0] FMAX = {1'b0, {(FORCE_WIDTH-1){1'b1}}};
	localparam logic [FORCE_WIDTH-1:0] FMIN = {1'b1, {(FORCE_WIDTH-1){1'b0}}};

	typedef logic signed [FORCE_WIDTH-1:0] force_t;
	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DIV, S_RESP} state_t;

	// saturating add; top bit of the result is the clamp flag
	function automatic logic [FORCE_WIDTH:0] sat_add(force_t a, logic signed [31:0] b);
		logic signed [SW-1:0] s;
		logic signed [SW-1:0] hi;
		logic signed [SW-1:0] lo;
		s  = SW'(a) + SW'(b);
		hi = SW'(signed'(FMAX));
		lo = SW'(signed'(FMIN));
		if (s > hi)
			return {1'b1, FMAX};
		else if (s < lo)
			return {1'b1, FMIN};
		else
			return {1'b0, s[FORCE_WIDTH-1:0]};
	endfunction

	function automatic logic [31:0] low32(force_t v);
		logic signed [SW-1:0] e;
		e = SW'(v);
		return e[31:0];
	endfunction

	state_t           state_q;
	logic [FUNC_W-1:0] func_q;
	logic [KEY_W-1:0]  key_q;
	logic [KIND_W-1:0] kind_q;
	logic signed [31:0] fin_q [3];
	logic [DIV_W-1:0]  dv_q;
	logic [CW-1:0]     n_q;
	logic [CW-1:0]     count_q;
	logic [IW-1:0]     k_q;
	logic              found_q;
	res_item_t         pend_q;
	logic              res_valid_q;
	res_item_t         res_data_q;

	// ring of cells; cell 0 is the head and feeds the processing unit
	logic [KEY_W-1:0]  key_c  [ENTRIES];
	logic [KIND_W-1:0] kind_c [ENTRIES];
	force_t            fx_c [ENTRIES];
	force_t            fy_c [ENTRIES];
	force_t            fz_c [ENTRIES];

	logic [KEY_W-1:0]  proc_key;
	logic [KIND_W-1:0] proc_kind;
	force_t            proc_fx, proc_fy, proc_fz;
	logic              shift_en;

	div_ctl_t div_ctl;
	force_t   div_qx, div_qy, div_qz;
	logic     div_sat, div_done;

	logic [FORCE_WIDTH:0] ax, ay, az;
	logic k_lt_n, k_end, is_match, is_append, slot_free, accept;
	logic emit_v;
	res_item_t emit_d;
	res_item_t pend_init;
	res_item_t pend_hit;

	for (genvar i = 0; i < ENTRIES; i++) begin : g_ring
		if (i == ENTRIES - 1) begin : g_tail
			kfat_cell #(.FORCE_WIDTH(FORCE_WIDTH)) u_cell (
				.clk(clk), .shift(shift_en),
				.d_key(proc_key), .d_kind(proc_kind),
				.d_fx(proc_fx), .d_fy(proc_fy), .d_fz(proc_fz),
				.q_key(key_c[i]), .q_kind(kind_c[i]),
				.q_fx(fx_c[i]), .q_fy(fy_c[i]), .q_fz(fz_c[i])
			);
		end else begin : g_mid
			kfat_cell #(.FORCE_WIDTH(FORCE_WIDTH)) u_cell (
				.clk(clk), .shift(shift_en),
				.d_key(key_c[i+1]), .d_kind(kind_c[i+1]),
				.d_fx(fx_c[i+1]), .d_fy(fy_c[i+1]), .d_fz(fz_c[i+1]),
				.q_key(key_c[i]), .q_kind(kind_c[i]),
				.q_fx(fx_c[i]), .q_fy(fy_c[i]), .q_fz(fz_c[i])
			);
		end
	end

	kfat_div #(.FORCE_WIDTH(FORCE_WIDTH)) u_div (
		.clk(clk), .arst_n(arst_n), .ctl(div_ctl),
		.fx(fx_c[0]), .fy(fy_c[0]), .fz(fz_c[0]), .divisor(dv_q),
		.qx(div_qx), .qy(div_qy), .qz(div_qz), .sat(div_sat), .done(div_done)
	);

	assign slot_free = !res_valid_q || res.ready;
	assign accept    = cmd.valid && cmd.ready;
	assign cmd.ready = state_q == S_IDLE;
	assign res.valid = res_valid_q;
	assign res.data  = res_data_q;

	always_comb begin
		k_lt_n    = CW'(k_q) < n_q;
		k_end     = k_q == IW'(ENTRIES - 1);
		is_match  = func_q == FUNC_ADD && k_lt_n && !found_q && key_c[0] == key_q;
		is_append = func_q == FUNC_ADD && CW'(k_q) == n_q && !found_q
			&& n_q != CW'(ENTRIES);
		ax = sat_add(is_append ? '0 : fx_c[0], fin_q[0]);
		ay = sat_add(is_append ? '0 : fy_c[0], fin_q[1]);
		az = sat_add(is_append ? '0 : fz_c[0], fin_q[2]);

		proc_key  = key_c[0];
		proc_kind = kind_c[0];
		proc_fx   = fx_c[0];
		proc_fy   = fy_c[0];
		proc_fz   = fz_c[0];
		if (is_match || is_append) begin
			proc_key  = is_append ? key_q : key_c[0];
			proc_kind = is_append ? kind_q : (kind_c[0] | kind_q);
			proc_fx   = ax[FORCE_WIDTH-1:0];
			proc_fy   = ay[FORCE_WIDTH-1:0];
			proc_fz   = az[FORCE_WIDTH-1:0];
		end else if (state_q == S_DIV) begin
			proc_fx = div_qx;
			proc_fy = div_qy;
			proc_fz = div_qz;
		end

		// default result: full table, or an all-zero special case
		pend_init             = '0;
		pend_init.status      = ST_FULL;
		pend_init.out_partner = cmd.data.partner;
		if (cmd.data.func != FUNC_ADD) begin
			if (cmd.data.func == FUNC_DIV && cmd.data.divisor == '0)
				pend_init.status = ST_DIVZERO;
			else
				pend_init.status = ST_EMPTY;
			pend_init.out_partner = '0;
		end

		// result of an add that touched an entry
		pend_hit               = pend_q;
		pend_hit.status        = is_append ? ST_APPENDED : ST_ACCUM;
		pend_hit.saturated     = ax[FORCE_WIDTH] | ay[FORCE_WIDTH] | az[FORCE_WIDTH];
		pend_hit.out_partner   = proc_key;
		pend_hit.out_kind_bits = proc_kind;
		pend_hit.out_force_x   = low32(proc_fx);
		pend_hit.out_force_y   = low32(proc_fy);
		pend_hit.out_force_z   = low32(proc_fz);

		shift_en = 1'b0;
		case (state_q)
			S_SCAN: begin
				case (func_q)
					FUNC_ADD:  shift_en = 1'b1;
					FUNC_READ: shift_en = !k_lt_n || slot_free;
					default:   shift_en = !k_lt_n;
				endcase
			end
			S_DIV:   shift_en = div_done && slot_free;
			default: shift_en = 1'b0;
		endcase

		div_ctl.start = state_q == S_SCAN && func_q == FUNC_DIV && k_lt_n;
		div_ctl.ack   = state_q == S_DIV && shift_en;

		emit_v               = 1'b0;
		emit_d               = pend_q;
		emit_d.last          = 1'b1;
		emit_d.status        = ST_ENTRY;
		if (state_q == S_RESP) begin
			emit_v = slot_free;
			emit_d = pend_q;
			emit_d.last = 1'b1;
		end else if ((state_q == S_SCAN && func_q == FUNC_READ && k_lt_n && slot_free)
				|| (state_q == S_DIV && shift_en)) begin
			emit_v = 1'b1;
			emit_d.status        = ST_ENTRY;
			emit_d.saturated     = state_q == S_DIV && div_sat;
			emit_d.out_partner   = proc_key;
			emit_d.out_kind_bits = proc_kind;
			emit_d.out_force_x   = low32(proc_fx);
			emit_d.out_force_y   = low32(proc_fy);
			emit_d.out_force_z   = low32(proc_fz);
			emit_d.last          = CW'(k_q) + CW'(1) == n_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			res_valid_q <= 1'b0;
			k_q         <= '0;
			found_q     <= 1'b0;
		end else begin
			if (emit_v)
				res_valid_q <= 1'b1;
			else if (res.ready)
				res_valid_q <= 1'b0;
			if (emit_v)
				res_data_q <= emit_d;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_q   <= cmd.data.func;
						key_q    <= cmd.data.partner;
						kind_q   <= cmd.data.kind_bits;
						fin_q[0] <= cmd.data.force_x;
						fin_q[1] <= cmd.data.force_y;
						fin_q[2] <= cmd.data.force_z;
						dv_q     <= cmd.data.divisor;
						n_q      <= count_q;
						k_q      <= '0;
						found_q  <= 1'b0;
						pend_q   <= pend_init;
						case (cmd.data.func)
							FUNC_CLEAR: count_q <= '0;
							FUNC_ADD:   state_q <= S_SCAN;
							default: begin
								if (cmd.data.func == FUNC_DIV && cmd.data.divisor == '0)
									state_q <= S_RESP;
								else if (count_q == '0)
									state_q <= S_RESP;
								else
									state_q <= S_SCAN;
							end
						endcase
					end
				end
				S_SCAN, S_DIV: begin
					if (is_match || is_append) begin
						found_q <= 1'b1;
						pend_q  <= pend_hit;
					end
					if (is_append)
						count_q <= n_q + CW'(1);
					if (div_ctl.start)
						state_q <= S_DIV;
					if (shift_en) begin
						k_q <= k_end ? '0 : k_q + IW'(1);
						if (k_end)
							state_q <= (func_q == FUNC_ADD) ? S_RESP : S_IDLE;
						else
							state_q <= S_SCAN;
					end
				end
				S_RESP: begin
					if (slot_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

>>> sv/kfat_checker.sv
module kfat_checker (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     cmd_valid,
	input logic                     cmd_ready,
	input logic [kfat_pkg::FUNC_W-1:0] cmd_func,
	input logic                     res_valid,
	input logic                     res_ready,
	input kfat_pkg::res_item_t      res_data
);
	import kfat_pkg::*;

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result dropped while stalled");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_func != FUNC_CLEAR |=> !cmd_ready)
		else $error("new command taken while an operation runs");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.status != ST_ENTRY |-> res_data.last)
		else $error("single result without last");

	a_zero_special: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.status == ST_DIVZERO || res_data.status == ST_EMPTY)
		|-> res_data.out_partner == '0 && !res_data.saturated)
		else $error("special result carries data");
endmodule

bind keyed_force_accumulator_table_top kfat_checker u_kfat_checker (
	.clk(clk), .arst_n(arst_n),
	.cmd_valid(cmd.valid), .cmd_ready(cmd.ready), .cmd_func(cmd.data.func),
	.res_valid(res.valid), .res_ready(res.ready), .res_data(res.data)
);
